/* design/catan_pkg.sv */
// ============================================================================
// catan_pkg: shared types and constants for the CORDIC atan2 unit
// Coordinate widths, normalize limits, arctangent table, command struct.
// ============================================================================
`default_nettype none

package catan_pkg;

   localparam int unsigned CoordW    = 64;
   localparam int unsigned HeadW     = 16;
   localparam int unsigned CordW     = 34;   // x/z after normalize, with CORDIC gain headroom
   localparam int unsigned TableLen  = 15;
   localparam int unsigned StepIdxW  = $clog2(TableLen);
   localparam int unsigned StepsDef  = 15;

   // Normalize walks shifts of 32,16,8,4,2,1 then one final single-bit fixup
   localparam int unsigned NormSteps = 7;
   localparam int unsigned NormIdxW  = $clog2(NormSteps);
   localparam int unsigned ShAmtW    = 6;
   localparam logic [NormIdxW-1:0] NormLast = NormIdxW'(NormSteps - 1);

   localparam logic [CoordW-1:0] UpperLimit  = CoordW'(1) << 30;
   localparam logic [CoordW-1:0] LowerTarget = CoordW'(1) << 28;

   localparam int unsigned QuadW = 2;

   typedef struct packed {
      logic                load;
      logic                norm;
      logic [NormIdxW-1:0] norm_idx;
      logic                cordic;
      logic [StepIdxW-1:0] cordic_idx;
      logic                store;
   } catan_cmd_type;

   // arctan(2^-i) in 1/65536 turn
   function automatic logic [HeadW-1:0] arc_tab(input logic [StepIdxW-1:0] idx);
      logic [HeadW-1:0] val;
      case (idx)
         4'd0:    val = 16'd8192;
         4'd1:    val = 16'd4836;
         4'd2:    val = 16'd2555;
         4'd3:    val = 16'd1297;
         4'd4:    val = 16'd651;
         4'd5:    val = 16'd326;
         4'd6:    val = 16'd163;
         4'd7:    val = 16'd81;
         4'd8:    val = 16'd41;
         4'd9:    val = 16'd20;
         4'd10:   val = 16'd10;
         4'd11:   val = 16'd5;
         4'd12:   val = 16'd3;
         4'd13:   val = 16'd1;
         4'd14:   val = 16'd1;
         default: val = 16'd0;
      endcase
      return val;
   endfunction

   // shift tried at each normalize step: 32 >> k, last step is a single bit
   function automatic logic [ShAmtW-1:0] norm_shift(input logic [NormIdxW-1:0] k);
      logic [ShAmtW-1:0] sh;
      if (k == NormLast) begin
         sh = ShAmtW'(1);
      end else begin
         sh = ShAmtW'(32) >> k;
      end
      return sh;
   endfunction

endpackage

`default_nettype wire

/* design/catan_ifs.sv */
// ============================================================================
// catan_ifs: request and response channels of the CORDIC atan2 unit
// Valid/ready channels; a beat moves when valid and ready are both high.
// ============================================================================
`default_nettype none

interface catan_req_if;
   import catan_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [CoordW-1:0] x_coord;
   logic signed [CoordW-1:0] z_coord;

   modport source (output valid, output x_coord, output z_coord, input ready);
   modport sink   (input valid, input x_coord, input z_coord, output ready);
endinterface

interface catan_rsp_if;
   import catan_pkg::*;

   logic             valid;
   logic             ready;
   logic [HeadW-1:0] heading;

   modport source (output valid, output heading, input ready);
   modport sink   (input valid, input heading, output ready);
endinterface

`default_nettype wire

/* design/catan_datapath.sv */
// ============================================================================
// catan_datapath: fold, normalize and CORDIC vectoring datapath
// Executes one command per cycle; holds the result register.
// ============================================================================
`default_nettype none

module catan_datapath (
   input  wire logic                                 clock,
   input  wire catan_pkg::catan_cmd_type             cmd,
   input  wire logic signed [catan_pkg::CoordW-1:0]  x_coord,
   input  wire logic signed [catan_pkg::CoordW-1:0]  z_coord,
   output logic             [catan_pkg::HeadW-1:0]   heading
);
   import catan_pkg::*;

   logic [CoordW-1:0]       a_ff, a_in;
   logic [CoordW-1:0]       b_ff, b_in;
   logic                    right_ff, right_in;
   logic                    zero_ff, zero_in;
   logic [QuadW-1:0]        quad_ff, quad_in;
   logic signed [CordW-1:0] x_ff, x_in;
   logic signed [CordW-1:0] z_ff, z_in;
   logic [HeadW-1:0]        ang_ff, ang_in;
   logic [HeadW-1:0]        heading_ff, heading_in;

   // fold
   logic [CoordW-1:0] x_raw, z_raw, x_mag, z_mag;
   logic [CoordW-1:0] fa, fb;
   logic [QuadW-1:0]  fq;

   // normalize
   logic [ShAmtW-1:0] app_sh, test_sh;
   logic              grow_right, grow_left;

   // cordic
   logic signed [CordW-1:0] x_cur, z_cur, sx, sz;
   logic [HeadW-1:0]        ang_cur, tab;
   logic                    z_pos;

   always_comb begin
      x_raw = x_coord;
      z_raw = z_coord;
      x_mag = ~x_raw + CoordW'(1);
      z_mag = ~z_raw + CoordW'(1);
      if (x_raw[CoordW-1] && !z_raw[CoordW-1]) begin
         fa = z_raw;
         fb = x_mag;
         fq = QuadW'(1);
      end else if (x_raw[CoordW-1]) begin
         fa = x_mag;
         fb = z_mag;
         fq = QuadW'(2);
      end else if (z_raw[CoordW-1]) begin
         fa = z_mag;
         fb = x_raw;
         fq = QuadW'(3);
      end else begin
         fa = x_raw;
         fb = z_raw;
         fq = QuadW'(0);
      end
   end

   always_comb begin
      app_sh     = norm_shift(cmd.norm_idx);
      test_sh    = (cmd.norm_idx == NormLast) ? '0 : app_sh;
      grow_right = ((a_ff >> test_sh) > UpperLimit) || ((b_ff >> test_sh) > UpperLimit);
      grow_left  = ((a_ff << test_sh) < LowerTarget) && ((b_ff << test_sh) < LowerTarget);
   end

   always_comb begin
      x_cur   = (cmd.cordic_idx == '0) ? $signed(a_ff[CordW-1:0]) : x_ff;
      z_cur   = (cmd.cordic_idx == '0) ? $signed(b_ff[CordW-1:0]) : z_ff;
      ang_cur = (cmd.cordic_idx == '0) ? '0 : ang_ff;
      sx      = x_cur >>> cmd.cordic_idx;
      sz      = z_cur >>> cmd.cordic_idx;
      tab     = arc_tab(cmd.cordic_idx);
      z_pos   = !z_cur[CordW-1] && (z_cur != '0);
   end

   always_comb begin
      a_in       = a_ff;
      b_in       = b_ff;
      right_in   = right_ff;
      zero_in    = zero_ff;
      quad_in    = quad_ff;
      x_in       = x_ff;
      z_in       = z_ff;
      ang_in     = ang_ff;
      heading_in = heading_ff;
      if (cmd.load) begin
         a_in     = fa;
         b_in     = fb;
         quad_in  = fq;
         zero_in  = (x_raw == '0) && (z_raw == '0);
         right_in = (fa > UpperLimit) || (fb > UpperLimit);
      end
      if (cmd.norm) begin
         if (right_ff && grow_right) begin
            a_in = a_ff >> app_sh;
            b_in = b_ff >> app_sh;
         end else if (!right_ff && grow_left) begin
            a_in = a_ff << app_sh;
            b_in = b_ff << app_sh;
         end
      end
      if (cmd.cordic) begin
         if (z_pos) begin
            x_in   = x_cur + sz;
            z_in   = z_cur - sx;
            ang_in = ang_cur + tab;
         end else begin
            x_in   = x_cur - sz;
            z_in   = z_cur + sx;
            ang_in = ang_cur - tab;
         end
      end
      if (cmd.store) begin
         heading_in = zero_ff ? '0 : (ang_ff + {quad_ff, (HeadW-QuadW)'(0)});
      end
   end

   always_ff @(posedge clock) begin
      a_ff       <= a_in;
      b_ff       <= b_in;
      right_ff   <= right_in;
      zero_ff    <= zero_in;
      quad_ff    <= quad_in;
      x_ff       <= x_in;
      z_ff       <= z_in;
      ang_ff     <= ang_in;
      heading_ff <= heading_in;
   end

   assign heading = heading_ff;

endmodule

`default_nettype wire

/* design/catan_ctrl.sv */
// ============================================================================
// catan_ctrl: sequencer for the CORDIC atan2 unit
// Steps load, normalize, CORDIC and store; owns both handshakes.
// ============================================================================
`default_nettype none

module catan_ctrl #(
   parameter int unsigned STEPS = catan_pkg::StepsDef
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output catan_pkg::catan_cmd_type      cmd
);
   import catan_pkg::*;

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StNorm = 2'd1;
   localparam logic [1:0] StCord = 2'd2;
   localparam logic [1:0] StDone = 2'd3;

   localparam logic [StepIdxW-1:0] CordLast = StepIdxW'(STEPS - 1);

   logic [1:0]          state_ff, state_in;
   logic [NormIdxW-1:0] nidx_ff, nidx_in;
   logic [StepIdxW-1:0] cidx_ff, cidx_in;
   logic                valid_ff, valid_in;
   logic                accept, slot_free;

   assign accept    = req_valid && (state_ff == StIdle);
   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      nidx_in        = nidx_ff;
      cidx_in        = cidx_ff;
      cmd            = '0;
      cmd.norm_idx   = nidx_ff;
      cmd.cordic_idx = cidx_ff;
      valid_in       = valid_ff && !rsp_ready;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               cmd.load = 1'b1;
               nidx_in  = '0;
               state_in = StNorm;
            end
         end
         StNorm: begin
            cmd.norm = 1'b1;
            nidx_in  = nidx_ff + NormIdxW'(1);
            if (nidx_ff == NormLast) begin
               cidx_in  = '0;
               state_in = StCord;
            end
         end
         StCord: begin
            cmd.cordic = 1'b1;
            cidx_in    = cidx_ff + StepIdxW'(1);
            if (cidx_ff == CordLast) begin
               state_in = StDone;
            end
         end
         StDone: begin
            if (slot_free) begin
               cmd.store = 1'b1;
               valid_in  = 1'b1;
               state_in  = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         nidx_ff  <= '0;
         cidx_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         nidx_ff  <= nidx_in;
         cidx_ff  <= cidx_in;
         valid_ff <= valid_in;
      end
   end

   assign req_ready = (state_ff == StIdle);
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

/* design/cordic_atan2_unit.sv */
// ============================================================================
// cordic_atan2_unit: heading of a signed 64-bit vector by CORDIC vectoring
// Folds to the first quadrant, normalizes, runs STEPS CORDIC iterations.
// ============================================================================
//
//  channel | dir | payload                         | handshake
//  --------+-----+---------------------------------+----------------------
//  req_if  | in  | x_coord, z_coord (s64 each)     | valid/ready, one beat
//  rsp_if  | out | heading (u16, 1/65536 turn)     | valid/ready, one beat
//
//  Sequence: a request beat is followed by the normalize steps (shift
//  search 32,16,8,4,2,1 then a one-bit fixup), STEPS CORDIC iterations on
//  the shared add/shift unit, and a store step. One item is in flight at
//  a time.
//  Reset: synchronous, active high; clears the sequencer and rsp valid.
//  Stalls: the result register holds a beat while rsp_if.ready is low; a
//  new request is taken meanwhile, and its store waits for the slot.
// ============================================================================
`default_nettype none

module cordic_atan2_unit #(
   parameter int unsigned STEPS = catan_pkg::StepsDef   // 1..15
) (
   input  wire logic  clock,
   input  wire logic  reset,
   catan_req_if.sink  req_if,
   catan_rsp_if.source rsp_if
);
   import catan_pkg::*;

   catan_cmd_type cmd;

   // sequencer: owns both handshakes and the step counters
   catan_ctrl #(
      .STEPS (STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   // datapath: samples the request on load, drives the held heading
   catan_datapath u_dp (
      .clock   (clock),
      .cmd     (cmd),
      .x_coord (req_if.x_coord),
      .z_coord (req_if.z_coord),
      .heading (rsp_if.heading)
   );

endmodule

`default_nettype wire
